### rtl/core/assert_macros.svh
// Assertion macros used by the core RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");
`else
`define ASSERT_SAME(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/ckws_pkg.sv
package ckws_pkg;

  localparam int MAX_KERNEL = 32;
  localparam int KSTORE     = MAX_KERNEL * MAX_KERNEL;
  localparam int ADDR_W     = $clog2(KSTORE);
  localparam int KS_W       = 6;
  localparam int POS_W      = $clog2(MAX_KERNEL);
  localparam int G_W        = $clog2(MAX_KERNEL + 1);
  localparam int WGT_W      = 16;
  localparam int ACC_W      = ADDR_W + WGT_W;
  localparam int SAT_W      = WGT_W + 1;
  localparam int OPA_W      = 9;
  localparam int PROD_W     = SAT_W + OPA_W;
  localparam int SCL_W      = PROD_W + 8;
  localparam int DIFF_W     = 17;
  localparam int ALPHA_W    = 8;

  localparam logic [KS_W-1:0]    KS_RESET  = KS_W'(2);
  localparam logic [SAT_W-1:0]   ONE_Q16   = SAT_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(255);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUNDS,
    ST_INIT,
    ST_SUM,
    ST_DRAIN,
    ST_SCALE,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic capture;
    logic bounds;
    logic init;
    logic issue;
    logic scale;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } dp_sts_t;

endpackage

### rtl/core/ckws_ctrl.sv
`include "assert_macros.svh"

module ckws_ctrl
  import ckws_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_mode,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    out_strobe
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_mode == MODE_QUERY) state_nxt = ST_BOUNDS;
      end
      ST_BOUNDS: state_nxt = ST_INIT;
      ST_INIT: begin
        state_nxt = sts.empty ? ST_SCALE : ST_SUM;
      end
      ST_SUM: begin
        if (sts.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_DONE;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.load    = start && in_mode == MODE_LOAD;
        cmd.capture = start && in_mode == MODE_QUERY;
      end
      ST_BOUNDS: cmd.bounds = 1'b1;
      ST_INIT:   cmd.init   = 1'b1;
      ST_SUM:    cmd.issue  = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_SCALE:  cmd.scale  = 1'b1;
      ST_FINISH: cmd.finish = 1'b1;
      ST_DONE:   out_strobe = 1'b1;
      default:   cmd        = '0;
    endcase
  end

  `ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  `ASSERT_NEXT(a_query_busy, start && !busy && in_mode == MODE_QUERY, busy)
  `ASSERT_NEXT(a_last_drains, cmd.issue && sts.last, state_r == ST_DRAIN)
  `ASSERT_SAME(a_load_idle, cmd.load, !busy && !cmd.capture)

endmodule

### rtl/core/ckws_datapath.sv
module ckws_datapath
  import ckws_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic                     cfg_we,
  input  logic [KS_W-1:0]          cfg_wdata,
  input  logic [ADDR_W-1:0]        in_weight_index,
  input  logic [WGT_W-1:0]         in_weight_value,
  input  logic signed [14:0]       in_pos_x,
  input  logic signed [14:0]       in_pos_y,
  input  logic [13:0]              in_win_width,
  input  logic [13:0]              in_win_height,
  input  logic [OPA_W-1:0]         in_opacity,
  output logic [ALPHA_W-1:0]       out_alpha
);

  logic [WGT_W-1:0] mem [KSTORE];

  logic [KS_W-1:0]   ks_r;
  logic [14:0]       x_r, y_r;
  logic [13:0]       w_r, h_r;
  logic [OPA_W-1:0]  op_r;
  logic [POS_W-1:0]  fx_lo_r, fx_hi_r, fy_lo_r, fy_hi_r, fx_r, fy_r;
  logic              empty_r;
  logic [ADDR_W-1:0] base_r;
  logic [WGT_W-1:0]  rd_q_r;
  logic              rd_vld_r;
  logic [ACC_W-1:0]  acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [ALPHA_W-1:0] alpha_r;

  logic [G_W-1:0]           g;
  logic [G_W-2:0]           c;
  logic signed [DIFF_W-1:0] gs, cs, xs, ys, dx0, dx1, dy0, dy1;
  logic signed [DIFF_W-1:0] fx0, fx1, fy0, fy1, fx1m, fy1m;
  logic                     empty_x, empty_y;
  logic [ADDR_W-1:0]        addr;
  logic [G_W+POS_W-1:0]     base_init;
  logic [SAT_W-1:0]         sat;
  logic [SCL_W-1:0]         scaled;
  logic [SCL_W-25:0]        a_hi;

  always_comb begin
    g  = (ks_r > KS_W'(MAX_KERNEL)) ? G_W'(MAX_KERNEL) : ks_r[G_W-1:0];
    c  = g[G_W-1:1];
    gs = $signed({{(DIFF_W-G_W){1'b0}}, g});
    cs = $signed({{(DIFF_W-G_W+1){1'b0}}, c});
    xs = $signed({{(DIFF_W-15){x_r[14]}}, x_r});
    ys = $signed({{(DIFF_W-15){y_r[14]}}, y_r});
    dx0 = cs - xs;
    dy0 = cs - ys;
    dx1 = $signed({{(DIFF_W-14){1'b0}}, w_r}) + cs - xs;
    dy1 = $signed({{(DIFF_W-14){1'b0}}, h_r}) + cs - ys;
    fx0 = dx0[DIFF_W-1] ? '0 : dx0;
    fy0 = dy0[DIFF_W-1] ? '0 : dy0;
    fx1 = (dx1 > gs) ? gs : dx1;
    fy1 = (dy1 > gs) ? gs : dy1;
    fx1m = fx1 - DIFF_W'(1);
    fy1m = fy1 - DIFF_W'(1);
    empty_x = fx0 >= fx1;
    empty_y = fy0 >= fy1;
    addr = base_r + {{(ADDR_W-POS_W){1'b0}}, fx_r};
    base_init = fy_lo_r * g;
    sat = (acc_r > {{(ACC_W-SAT_W){1'b0}}, ONE_Q16}) ? ONE_Q16 : acc_r[SAT_W-1:0];
    scaled = {prod_r, 8'b0} - {8'b0, prod_r};
    a_hi = scaled[SCL_W-1:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r <= KS_RESET;
    end else if (cfg_we) begin
      ks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[in_weight_index] <= in_weight_value;
    end
    if (cmd.issue) begin
      rd_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r  <= in_pos_x;
      y_r  <= in_pos_y;
      w_r  <= in_win_width;
      h_r  <= in_win_height;
      op_r <= in_opacity;
    end
    if (cmd.bounds) begin
      empty_r <= empty_x || empty_y;
      fx_lo_r <= fx0[POS_W-1:0];
      fy_lo_r <= fy0[POS_W-1:0];
      fx_hi_r <= fx1m[POS_W-1:0];
      fy_hi_r <= fy1m[POS_W-1:0];
    end
    if (cmd.init) begin
      fx_r   <= fx_lo_r;
      fy_r   <= fy_lo_r;
      base_r <= base_init[ADDR_W-1:0];
    end else if (cmd.issue) begin
      if (fx_r == fx_hi_r) begin
        fx_r   <= fx_lo_r;
        fy_r   <= fy_r + POS_W'(1);
        base_r <= base_r + {{(ADDR_W-G_W){1'b0}}, g};
      end else begin
        fx_r <= fx_r + POS_W'(1);
      end
    end
    if (cmd.init) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + {{(ACC_W-WGT_W){1'b0}}, rd_q_r};
    end
    if (cmd.scale) begin
      prod_r <= sat * op_r;
    end
    if (cmd.finish) begin
      alpha_r <= (a_hi > {{(SCL_W-24-ALPHA_W){1'b0}}, ALPHA_MAX}) ? ALPHA_MAX
                                                                 : a_hi[ALPHA_W-1:0];
    end
  end

  assign sts.empty = empty_r;
  assign sts.last  = (fx_r == fx_hi_r) && (fy_r == fy_hi_r);
  assign out_alpha = alpha_r;

endmodule

### rtl/core/clipped_kernel_window_sum_unit.sv
// Load (mode 0): written in the accept cycle, busy never rises, one load per cycle.
// Query (mode 1): BOUNDS, INIT, SUM, DRAIN, SCALE, FINISH, DONE; out_strobe in DONE;
// SUM reads N = clipped rows x clipped columns (1 to 1024) weights, one per cycle, from
// the single-port kernel memory. Busy stays high until IDLE, so the next item waits;
// an empty window skips SUM and DRAIN. Results cannot be stalled. Synchronous
// active-low reset clears control and sets kernel_size to 2; weights are not reset.
module clipped_kernel_window_sum_unit
  import ckws_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [ADDR_W-1:0]   in_weight_index,
  input  logic [WGT_W-1:0]    in_weight_value,
  input  logic signed [14:0]  in_pos_x,
  input  logic signed [14:0]  in_pos_y,
  input  logic [13:0]         in_win_width,
  input  logic [13:0]         in_win_height,
  input  logic [OPA_W-1:0]    in_opacity,
  output logic                out_strobe,
  output logic [ALPHA_W-1:0]  out_alpha,
  input  logic                cfg_we,
  input  logic [KS_W-1:0]     cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ckws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_mode),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  ckws_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_weight_index (in_weight_index),
    .in_weight_value (in_weight_value),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_win_width    (in_win_width),
    .in_win_height   (in_win_height),
    .in_opacity      (in_opacity),
    .out_alpha       (out_alpha)
  );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ckws_pkg::*;

  typedef struct {
    logic               mode;
    logic [ADDR_W-1:0]  widx;
    logic [WGT_W-1:0]   wval;
    logic signed [14:0] px;
    logic signed [14:0] py;
    logic [13:0]        ww;
    logic [13:0]        wh;
    logic [OPA_W-1:0]   opa;
  } shadow_item_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_mode;
  logic [ADDR_W-1:0]  in_weight_index;
  logic [WGT_W-1:0]   in_weight_value;
  logic signed [14:0] in_pos_x;
  logic signed [14:0] in_pos_y;
  logic [13:0]        in_win_width;
  logic [13:0]        in_win_height;
  logic [OPA_W-1:0]   in_opacity;
  logic               out_strobe;
  logic [ALPHA_W-1:0] out_alpha;
  logic               cfg_we;
  logic [KS_W-1:0]    cfg_wdata;

  logic [WGT_W-1:0]   kernel_store [KSTORE];
  bit                 weight_written [KSTORE];
  logic [KS_W-1:0]    kernel_size_model;
  logic [ALPHA_W-1:0] pending_alpha [$];
  logic [ALPHA_W-1:0] expected_alpha;
  bit                 gaps_on = 1'b1;
  int                 fail_count;
  int                 load_count;
  int                 query_count;
  int                 saturated_count;
  int                 zero_sum_count;
  int                 widest_query;
  int                 size_writes;

  clipped_kernel_window_sum_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_weight_index (in_weight_index),
    .in_weight_value (in_weight_value),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_win_width    (in_win_width),
    .in_win_height   (in_win_height),
    .in_opacity      (in_opacity),
    .out_strobe      (out_strobe),
    .out_alpha       (out_alpha),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_size();
    return (kernel_size_model > MAX_KERNEL) ? MAX_KERNEL : int'(kernel_size_model);
  endfunction

  function automatic void window_span(input shadow_item_t it,
                                      output int x0, x1, y0, y1, g);
    int c;
    g  = active_size();
    c  = g / 2;
    x0 = c - int'(it.px);
    x1 = int'(it.ww) + c - int'(it.px);
    y0 = c - int'(it.py);
    y1 = int'(it.wh) + c - int'(it.py);
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > g) x1 = g;
    if (y1 > g) y1 = g;
  endfunction

  function automatic logic [ALPHA_W-1:0] shadow_alpha(input shadow_item_t it,
                                                      output logic [SAT_W-1:0] total);
    int          x0, x1, y0, y1, g;
    logic [31:0] acc;
    logic [63:0] scaled;
    window_span(it, x0, x1, y0, y1, g);
    acc = '0;
    for (int fy = y0; fy < y1; fy++)
      for (int fx = x0; fx < x1; fx++)
        acc += kernel_store[(fy * g + fx) % KSTORE];
    if (acc > ONE_Q16) acc = ONE_Q16;
    total  = acc[SAT_W-1:0];
    scaled = (64'(acc) * 64'(it.opa) * 64'd255) >> 24;
    return (scaled > ALPHA_MAX) ? ALPHA_MAX : scaled[ALPHA_W-1:0];
  endfunction

  function automatic bit reads_written(input shadow_item_t it);
    int x0, x1, y0, y1, g;
    window_span(it, x0, x1, y0, y1, g);
    for (int fy = y0; fy < y1; fy++)
      for (int fx = x0; fx < x1; fx++)
        if (!weight_written[(fy * g + fx) % KSTORE]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string what,
                                       input logic [ALPHA_W-1:0] want, got);
    if (fail_count < 10) $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endfunction

  function automatic void record_transfer(input shadow_item_t it);
    logic [SAT_W-1:0] total;
    int               x0, x1, y0, y1, g;
    if (it.mode == MODE_LOAD) begin
      kernel_store[it.widx]   = it.wval;
      weight_written[it.widx] = 1'b1;
      load_count++;
    end else begin
      pending_alpha.push_back(shadow_alpha(it, total));
      window_span(it, x0, x1, y0, y1, g);
      if (x1 > x0 && y1 > y0 && (x1 - x0) * (y1 - y0) > widest_query)
        widest_query = (x1 - x0) * (y1 - y0);
      if (total == ONE_Q16) saturated_count++;
      if (total == '0) zero_sum_count++;
      query_count++;
    end
  endfunction

  function automatic shadow_item_t load_item(input int idx, input logic [WGT_W-1:0] val);
    shadow_item_t it;
    it.mode = MODE_LOAD;
    it.widx = ADDR_W'(idx);
    it.wval = val;
    it.px   = 15'($urandom);
    it.py   = 15'($urandom);
    it.ww   = 14'($urandom);
    it.wh   = 14'($urandom);
    it.opa  = OPA_W'($urandom);
    return it;
  endfunction

  function automatic shadow_item_t query_item(input int x, y, w, h, opa);
    shadow_item_t it;
    it.mode = MODE_QUERY;
    it.widx = ADDR_W'($urandom);
    it.wval = WGT_W'($urandom);
    it.px   = 15'(x);
    it.py   = 15'(y);
    it.ww   = 14'(w);
    it.wh   = 14'(h);
    it.opa  = OPA_W'(opa);
    return it;
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return WGT_W'($urandom);
      1:       return 16'hFFFF;
      default: return WGT_W'($urandom_range(0, 32'hFFFF >> $urandom_range(4, 12)));
    endcase
  endfunction

  function automatic int edge_pos();
    case ($urandom_range(0, 5))
      0:       return -16384;
      1:       return -64;
      2:       return -1;
      3:       return 0;
      4:       return 16383;
      default: return int'($urandom_range(0, 32767)) - 16384;
    endcase
  endfunction

  function automatic int edge_len();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return 16383;
      default: return $urandom_range(0, 16383);
    endcase
  endfunction

  function automatic shadow_item_t rand_query();
    int g, c, x, y, w, h, opa;
    g = active_size();
    c = g / 2;
    x = int'($urandom_range(0, g + 16)) - 8;
    y = int'($urandom_range(0, g + 16)) - 8;
    w = $urandom_range(0, g + 4);
    h = $urandom_range(0, g + 4);
    case ($urandom_range(0, 9))
      0: begin
        x = edge_pos();
        y = edge_pos();
        w = edge_len();
        h = edge_len();
      end
      1, 2: begin
        y = c + int'($urandom_range(0, 6));
        h = $urandom_range(0, 2);
      end
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0:       opa = 0;
      1:       opa = 256;
      2:       opa = 511;
      3:       opa = 255;
      default: opa = $urandom_range(0, 511);
    endcase
    return query_item(x, y, w, h, opa);
  endfunction

  function automatic int pick_gap();
    if (!gaps_on) return 0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
      17, 18:                       return $urandom_range(4, 10);
      19:                           return $urandom_range(11, 40);
      default:                      return $urandom_range(1, 3);
    endcase
  endfunction

  task automatic send_item(input shadow_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= it.mode;
    in_weight_index <= it.widx;
    in_weight_value <= it.wval;
    in_pos_x        <= it.px;
    in_pos_y        <= it.py;
    in_win_width    <= it.ww;
    in_win_height   <= it.wh;
    in_opacity      <= it.opa;
    do @(posedge clk); while (busy);
    record_transfer(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_alpha.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_kernel_size(input logic [KS_W-1:0] ks);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= ks;
    @(posedge clk);
    cfg_we            <= 1'b0;
    kernel_size_model  = ks;
    size_writes++;
  endtask

  task automatic test_load_and_saturation();
    send_item(load_item(0, 16'hFFFF));
    send_item(load_item(1, 16'h0001));
    send_item(load_item(2, 16'h8000));
    send_item(load_item(3, 16'h0000));
    send_item(load_item(KSTORE - 1, 16'hFFFF));
    send_item(query_item(1, 1, 16383, 16383, 256));
    send_item(query_item(1, 1, 16383, 16383, 511));
    send_item(query_item(1, 1, 16383, 16383, 0));
    send_item(query_item(1, 1, 1, 1, 255));
    send_item(query_item(2, 1, 1, 1, 1));
    send_item(query_item(-16384, -16384, 16383, 16383, 256));
    send_item(query_item(16383, 16383, 16383, 16383, 256));
    send_item(query_item(1, 0, 1, 1, 256));
  endtask

  task automatic test_kernel_size_corners();
    set_kernel_size(6'd0);
    send_item(query_item(0, 0, 16383, 16383, 256));
    set_kernel_size(6'd1);
    send_item(query_item(0, 0, 1, 1, 256));
    set_kernel_size(6'd3);
    send_item(query_item(1, 1, 1, 1, 256));
    send_item(query_item(2, 2, 2, 2, 200));
    set_kernel_size(6'd63);
    send_item(query_item(16, 16, 2, 1, 256));
    send_item(query_item(16383, 16383, 0, 0, 256));
    send_item(query_item(-64, -64, 16383, 16383, 77));
  endtask

  task automatic run_phase(input logic [KS_W-1:0] ks, input int count);
    shadow_item_t it;
    int           g;
    int           span;
    set_kernel_size(ks);
    g = active_size();
    for (int i = 0; i < g * g && i < 64; i++)
      if (!weight_written[i]) send_item(load_item(i, pick_weight()));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 24) == 0) drain_results();
      if ($urandom_range(0, 9) < 3) begin
        span = (g == 0 || $urandom_range(0, 3) == 0) ? KSTORE : g * g;
        send_item(load_item($urandom_range(0, span - 1), pick_weight()));
      end else begin
        it = rand_query();
        for (int t = 0; t < 40 && !reads_written(it); t++) it = rand_query();
        // fall back to an empty column range
        if (!reads_written(it)) it.ww = '0;
        send_item(it);
      end
    end
  endtask

  task automatic test_random_windows();
    logic [KS_W-1:0] sizes [13] = '{2, 6, 4, 8, 1, 16, 3, 0, 32, 63, 12, 40, 5};
    foreach (sizes[p]) begin
      gaps_on = (p % 4 != 3);
      run_phase(sizes[p], 38);
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_alpha.size() == 0) begin
        note_failure("alpha with no query waiting", 'x, out_alpha);
      end else begin
        expected_alpha = pending_alpha.pop_front();
        if (out_alpha !== expected_alpha) note_failure("alpha mismatch", expected_alpha, out_alpha);
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_mode           <= MODE_LOAD;
    in_weight_index   <= '0;
    in_weight_value   <= '0;
    in_pos_x          <= '0;
    in_pos_y          <= '0;
    in_win_width      <= '0;
    in_win_height     <= '0;
    in_opacity        <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    kernel_size_model  = KS_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_and_saturation();
    test_kernel_size_corners();
    test_random_windows();
    drain_results();
    repeat (1040) @(posedge clk);
    if (pending_alpha.size() != 0) note_failure("query left without alpha", pending_alpha[0], 'x);
    $display("covered %0d weight loads and %0d shadow queries over %0d kernel size writes",
             load_count, query_count, size_writes);
    $display("%0d sums clamped at one, %0d empty or zero sums, widest query %0d weights",
             saturated_count, zero_sum_count, widest_query);
    if (fail_count == 0) begin
      $display("clipped_kernel_window_sum_unit regression: pass");
    end else begin
      $display("clipped_kernel_window_sum_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("run timed out");
    $display("clipped_kernel_window_sum_unit regression: fail");
    $finish;
  end

endmodule
